>>> rtl/nsfc_pkg.sv
// Shared constants and types of the positioning sentence framer.
`default_nettype none
package nsfc_pkg;

   // Characters that frame and identify a sentence.
   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_G       = 8'h47;
   localparam logic [7:0] CHAR_R       = 8'h52;
   localparam logic [7:0] CHAR_M       = 8'h4D;
   localparam logic [7:0] CHAR_C       = 8'h43;
   localparam logic [7:0] CHAR_A       = 8'h41;

   // Shortest line that may be forwarded, and the header bytes kept for matching.
   localparam int MIN_LINE  = 7;
   localparam int HDR_BYTES = 6;

   // Transfer unit handling.
   localparam int        MTU_W        = 10;
   localparam logic [9:0] MIN_MTU      = 10'd23;
   localparam logic [9:0] MTU_OVERHEAD = 10'd3;

   // Result word layout.
   localparam int WORD_BYTES = 8;
   localparam int DATA_W     = 64;
   localparam int COUNT_W    = 4;

   typedef enum logic [1:0] {
      CSR_LINK_CONNECTED = 2'd0,
      CSR_FIRST_ON       = 2'd1,
      CSR_SECOND_ON      = 2'd2,
      CSR_LINK_MTU       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      RD_IDLE  = 2'd0,
      RD_FETCH = 2'd1,
      RD_PACK  = 2'd2,
      RD_OUT   = 2'd3
   } readout_state_type;

endpackage
`default_nettype wire

>>> rtl/nsfc_line_capture.sv
// Line capture: collects one sentence into the line memory and flags a matching line end.
`default_nettype none
module nsfc_line_capture #(
   parameter int LINE_BYTES = 128
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            byte_valid,
   input  wire logic [7:0]                      byte_data,
   input  wire logic [$clog2(LINE_BYTES)-1:0]   rd_addr,
   output logic      [7:0]                      rd_data,
   output logic                                 line_go,
   output logic      [$clog2(LINE_BYTES)-1:0]   line_len
);

   localparam int CNT_W = $clog2(LINE_BYTES);

   logic [7:0]       mem_ff [LINE_BYTES];
   logic [7:0]       rd_data_ff;
   logic [7:0]       hdr_ff [1:5];
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;
   logic             capturing_ff;
   logic             capturing_in;
   logic [CNT_W-1:0] fill_plus;
   logic             room;
   logic             wr_en;
   logic [CNT_W-1:0] wr_addr;
   logic             hdr_match;

   assign fill_plus = fill_ff + CNT_W'(1);
   assign room      = (fill_ff < CNT_W'(LINE_BYTES - 1));
   assign line_len  = fill_plus;
   assign rd_data   = rd_data_ff;

   // Header check covers $G?RMC and $G?GGA; byte zero is always the dollar sign.
   assign hdr_match = (hdr_ff[1] == nsfc_pkg::CHAR_G) &&
                      (((hdr_ff[3] == nsfc_pkg::CHAR_R) && (hdr_ff[4] == nsfc_pkg::CHAR_M) &&
                        (hdr_ff[5] == nsfc_pkg::CHAR_C)) ||
                       ((hdr_ff[3] == nsfc_pkg::CHAR_G) && (hdr_ff[4] == nsfc_pkg::CHAR_G) &&
                        (hdr_ff[5] == nsfc_pkg::CHAR_A)));

   always_comb begin
      fill_in      = fill_ff;
      capturing_in = capturing_ff;
      wr_en        = 1'b0;
      wr_addr      = fill_ff;
      line_go      = 1'b0;
      if (byte_valid) begin
         if (byte_data == nsfc_pkg::CHAR_DOLLAR) begin
            capturing_in = 1'b1;
            fill_in      = CNT_W'(1);
            wr_en        = 1'b1;
            wr_addr      = '0;
         end else if (capturing_ff) begin
            if (room) begin
               wr_en   = 1'b1;
               fill_in = fill_plus;
            end else begin
               capturing_in = 1'b0;
               fill_in      = '0;
            end
            if (byte_data == nsfc_pkg::CHAR_NEWLINE) begin
               line_go      = room && (fill_plus >= CNT_W'(nsfc_pkg::MIN_LINE)) && hdr_match;
               capturing_in = 1'b0;
               fill_in      = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         capturing_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         capturing_ff <= capturing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= byte_data;
      end
      if (wr_en && (wr_addr != '0) && (wr_addr < CNT_W'(nsfc_pkg::HDR_BYTES))) begin
         hdr_ff[wr_addr[2:0]] <= byte_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> rtl/nmea_sentence_filter_chunker_top.sv
// Top level of the positioning sentence framer: configuration, readout sequencer and result port.
// Bytes from the receiver enter one per beat on the req_ channel and are written into a line
// memory of LINE_BYTES entries; a '$' always restarts the line. When a newline closes a line of
// at least seven bytes that reads $G?RMC or $G?GGA, and the link is connected with at least one
// service subscribed, the line (newline included) is read back one byte per cycle within a word,
// through the memory's single registered read port, and packed into result words of up to eight
// bytes, the earliest byte lowest. Words never straddle a notification chunk of link_mtu - 3 bytes
// (a link_mtu below 23 counts as 23). Each word restarts the memory read in RD_FETCH and then
// waits in the output register in RD_OUT until the result side takes it; for the whole readout
// req_tready is low and no new byte is accepted. Configuration writes on the csr_ port are
// always accepted and must only be issued while no line is being read out.
`default_nettype none
module nmea_sentence_filter_chunker_top #(
   parameter int LINE_BYTES = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input stream, one received byte per beat.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   // Result stream, one packed word per beat.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [63:0] chunk_data, [67:64] byte_count, rest zero
   output logic             rsp_tlast,   // sentence_end
   output logic [2:0]       rsp_tuser,   // [0] chunk_end, [1] to_first_service,
                                         // [2] to_second_service
   // Configuration writes.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [9:0]  csr_data
);

   localparam int CNT_W = $clog2(LINE_BYTES);
   localparam int MTU_W = nsfc_pkg::MTU_W;

   nsfc_pkg::readout_state_type state_ff;
   nsfc_pkg::readout_state_type state_in;

   // Configuration registers.
   logic             link_ff;
   logic             first_ff;
   logic             second_ff;
   logic [MTU_W-1:0] mtu_ff;
   logic [MTU_W-1:0] payload;

   // Capture interface.
   logic             byte_accept;
   logic [7:0]       rd_data;
   logic             line_go;
   logic [CNT_W-1:0] line_len;
   logic             emit_go;

   // Readout counters and the word being assembled.
   logic [CNT_W-1:0] rd_idx_ff;
   logic [CNT_W-1:0] rd_idx_in;
   logic [CNT_W-1:0] line_left_ff;
   logic [CNT_W-1:0] line_left_in;
   logic [MTU_W-1:0] chunk_left_ff;
   logic [MTU_W-1:0] chunk_left_in;
   logic [nsfc_pkg::COUNT_W-1:0] word_cnt_ff;
   logic [nsfc_pkg::COUNT_W-1:0] word_cnt_in;
   logic [nsfc_pkg::COUNT_W-1:0] cnt_plus;
   logic [nsfc_pkg::DATA_W-1:0]  word_ff;
   logic [nsfc_pkg::DATA_W-1:0]  word_in;
   logic [nsfc_pkg::DATA_W-1:0]  packed_word;
   logic             line_last;
   logic             chunk_last;
   logic             word_close;

   // Output register.
   logic [nsfc_pkg::DATA_W-1:0]  rsp_data_ff;
   logic [nsfc_pkg::DATA_W-1:0]  rsp_data_in;
   logic [nsfc_pkg::COUNT_W-1:0] rsp_cnt_ff;
   logic [nsfc_pkg::COUNT_W-1:0] rsp_cnt_in;
   logic             rsp_chunk_end_ff;
   logic             rsp_chunk_end_in;
   logic             rsp_last_ff;
   logic             rsp_last_in;

   assign csr_ready   = 1'b1;
   assign req_tready  = (state_ff == nsfc_pkg::RD_IDLE);
   assign byte_accept = req_tvalid && req_tready;
   assign emit_go     = line_go && link_ff && (first_ff || second_ff);

   // Chunk payload is the transfer unit less the notification header, with a floor of 20 bytes.
   assign payload = ((mtu_ff < nsfc_pkg::MIN_MTU) ? nsfc_pkg::MIN_MTU : mtu_ff)
                    - nsfc_pkg::MTU_OVERHEAD;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff   <= 1'b0;
         first_ff  <= 1'b0;
         second_ff <= 1'b0;
         mtu_ff    <= nsfc_pkg::MIN_MTU;
      end else if (csr_valid && csr_ready) begin
         case (nsfc_pkg::csr_index_type'(csr_index))
            nsfc_pkg::CSR_LINK_CONNECTED: link_ff   <= csr_data[0];
            nsfc_pkg::CSR_FIRST_ON:       first_ff  <= csr_data[0];
            nsfc_pkg::CSR_SECOND_ON:      second_ff <= csr_data[0];
            nsfc_pkg::CSR_LINK_MTU:       mtu_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   nsfc_line_capture #(
      .LINE_BYTES (LINE_BYTES)
   ) u_capture (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_accept),
      .byte_data  (req_tdata),
      .rd_addr    (rd_idx_ff),
      .rd_data    (rd_data),
      .line_go    (line_go),
      .line_len   (line_len)
   );

   // The byte read from memory lands in the lane selected by the word's fill count.
   assign cnt_plus   = word_cnt_ff + nsfc_pkg::COUNT_W'(1);
   assign line_last  = (line_left_ff == CNT_W'(1));
   assign chunk_last = (chunk_left_ff == MTU_W'(1)) || line_last;
   assign word_close = (cnt_plus == nsfc_pkg::COUNT_W'(nsfc_pkg::WORD_BYTES)) || chunk_last;

   always_comb begin
      packed_word = word_ff;
      packed_word[{word_cnt_ff[2:0], 3'b000} +: 8] = rd_data;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nsfc_pkg::RD_IDLE: begin
            if (emit_go) begin
               state_in = nsfc_pkg::RD_FETCH;
            end
         end
         nsfc_pkg::RD_FETCH: begin
            state_in = nsfc_pkg::RD_PACK;
         end
         nsfc_pkg::RD_PACK: begin
            if (word_close) begin
               state_in = nsfc_pkg::RD_OUT;
            end
         end
         nsfc_pkg::RD_OUT: begin
            if (rsp_tready) begin
               state_in = rsp_last_ff ? nsfc_pkg::RD_IDLE : nsfc_pkg::RD_FETCH;
            end
         end
         default: state_in = nsfc_pkg::RD_IDLE;
      endcase
   end

   // Datapath controls and outputs.
   always_comb begin
      rd_idx_in        = rd_idx_ff;
      line_left_in     = line_left_ff;
      chunk_left_in    = chunk_left_ff;
      word_cnt_in      = word_cnt_ff;
      word_in          = word_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_cnt_in       = rsp_cnt_ff;
      rsp_chunk_end_in = rsp_chunk_end_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_tvalid       = 1'b0;
      case (state_ff)
         nsfc_pkg::RD_IDLE: begin
            rd_idx_in     = '0;
            line_left_in  = line_len;
            chunk_left_in = payload;
            word_cnt_in   = '0;
            word_in       = '0;
         end
         nsfc_pkg::RD_FETCH: begin
            rd_idx_in = rd_idx_ff + CNT_W'(1);
         end
         nsfc_pkg::RD_PACK: begin
            line_left_in  = line_left_ff - CNT_W'(1);
            chunk_left_in = chunk_last ? payload : (chunk_left_ff - MTU_W'(1));
            if (word_close) begin
               rsp_data_in      = packed_word;
               rsp_cnt_in       = cnt_plus;
               rsp_chunk_end_in = chunk_last;
               rsp_last_in      = line_last;
               word_in          = '0;
               word_cnt_in      = '0;
            end else begin
               rd_idx_in   = rd_idx_ff + CNT_W'(1);
               word_in     = packed_word;
               word_cnt_in = cnt_plus;
            end
         end
         nsfc_pkg::RD_OUT: begin
            rsp_tvalid = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nsfc_pkg::RD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff        <= rd_idx_in;
      line_left_ff     <= line_left_in;
      chunk_left_ff    <= chunk_left_in;
      word_cnt_ff      <= word_cnt_in;
      word_ff          <= word_in;
      rsp_data_ff      <= rsp_data_in;
      rsp_cnt_ff       <= rsp_cnt_in;
      rsp_chunk_end_ff <= rsp_chunk_end_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_tdata = {4'b0000, rsp_cnt_ff, rsp_data_ff};
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = {second_ff, first_ff, rsp_chunk_end_ff};

endmodule
`default_nettype wire

>>> sim/tb_nmea_sentence_filter_chunker_top.sv
// Self-checking testbench for the positioning sentence framer with random stream traffic.
`timescale 1ns / 100ps
module tb_nmea_sentence_filter_chunker_top;

   // The line memory size used for the block and for the predictor alike.
   localparam int LINE_BYTES = 128;
   // Cycles that may pass without any beat before the run is declared hung. The longest
   // correct quiet stretch is the deliberate receiver hold-off below plus one readout.
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   // Quiet cycles after the last expected word between settings, and at the very end,
   // where a full-length line with its largest word count would still fit.
   localparam int PHASE_SETTLE = 32;
   localparam int FINAL_SETTLE = 200;
   localparam int PHASE_BYTES = 12;
   localparam int MAX_REPORTS = 40;

   // One result word as the block should present it.
   typedef struct {
      logic [63:0] data;
      logic [3:0]  count;
      logic        chunk_end;
      logic        sentence_end;
      logic        to_first;
      logic        to_second;
   } chunk_word_type;

   // Shapes of generated sentences; an off header has one of its identifying bytes altered.
   typedef enum {
      LINE_RMC,
      LINE_GGA,
      LINE_OFF_HEADER
   } line_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic [2:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = nsfc_pkg::CSR_LINK_CONNECTED;
   logic [9:0]  csr_data = 10'd0;

   nmea_sentence_filter_chunker_top #(
      .LINE_BYTES(LINE_BYTES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),     // [7:0] rx_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),     // [63:0] chunk_data, [67:64] byte_count, rest zero
      .rsp_tlast  (rsp_tlast),     // sentence_end
      .rsp_tuser  (rsp_tuser),     // [0] chunk_end, [1] to_first_service, [2] to_second_service
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // Predictor state: the register settings as last written, and the line being assembled.
   logic        cfg_connected = 1'b0;
   logic        cfg_first = 1'b0;
   logic        cfg_second = 1'b0;
   logic [9:0]  cfg_mtu = nsfc_pkg::MIN_MTU;
   logic [7:0]  line_mem [LINE_BYTES];
   int          fill_count = 0;
   logic        capturing = 1'b0;

   // Receiver bytes waiting to be driven, and words the block still owes us.
   logic [7:0]     byte_queue [$];
   chunk_word_type pending_words [$];

   // Traffic shaping, set by the stimulus process between settings.
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          hold_requests = 0;
   int          holds_started = 0;
   int          hold_left = 0;

   // Bookkeeping for the summary and the verdict.
   int          bytes_queued = 0;
   int          bytes_accepted = 0;
   int          words_checked = 0;
   int          lines_forwarded = 0;
   int          most_words = 0;
   int          settings_applied = 0;
   int          error_count = 0;
   int unsigned quiet_cycles = 0;

   // Cut a finished line into chunks of (mtu - 3) bytes and each chunk into words of up to
   // eight bytes. Nothing leaves unless the link is up and some service is subscribed.
   function automatic void forward_line(int len);
      int unsigned    mtu;
      int unsigned    payload;
      int unsigned    off;
      int unsigned    pos;
      int unsigned    chunk;
      int unsigned    n;
      int             words;
      chunk_word_type w;
      mtu = (cfg_mtu < nsfc_pkg::MIN_MTU) ? nsfc_pkg::MIN_MTU : cfg_mtu;
      payload = mtu - nsfc_pkg::MTU_OVERHEAD;
      if (!cfg_connected || !(cfg_first || cfg_second))
         return;
      off = 0;
      words = 0;
      while (off < len) begin
         chunk = (len - off > payload) ? payload : len - off;
         pos = 0;
         while (pos < chunk) begin
            n = (chunk - pos > 8) ? 8 : chunk - pos;
            w.data = 64'd0;
            for (int i = 0; i < n; i++)
               w.data |= 64'(line_mem[off + pos + i]) << (8 * i);
            w.count = 4'(n);
            w.chunk_end = (pos + n == chunk);
            w.sentence_end = (off + pos + n == len);
            w.to_first = cfg_first;
            w.to_second = cfg_second;
            pending_words.push_back(w);
            words++;
            pos += n;
         end
         off += chunk;
      end
      lines_forwarded++;
      if (words > most_words)
         most_words = words;
   endfunction

   // Advance the line assembler by one accepted receiver byte.
   function automatic void frame_byte(logic [7:0] c);
      if (c == nsfc_pkg::CHAR_DOLLAR) begin
         // A dollar sign restarts the line wherever it appears.
         capturing = 1'b1;
         line_mem[0] = c;
         fill_count = 1;
         return;
      end
      if (!capturing)
         return;
      if (fill_count < LINE_BYTES - 1) begin
         line_mem[fill_count] = c;
         fill_count++;
      end else begin
         // The line would not fit; drop it, and a newline here then finds nothing to send.
         capturing = 1'b0;
         fill_count = 0;
      end
      if (c == nsfc_pkg::CHAR_NEWLINE) begin
         if (fill_count >= nsfc_pkg::MIN_LINE && line_mem[0] == nsfc_pkg::CHAR_DOLLAR &&
             line_mem[1] == nsfc_pkg::CHAR_G &&
             ((line_mem[3] == nsfc_pkg::CHAR_R && line_mem[4] == nsfc_pkg::CHAR_M &&
               line_mem[5] == nsfc_pkg::CHAR_C) ||
              (line_mem[3] == nsfc_pkg::CHAR_G && line_mem[4] == nsfc_pkg::CHAR_G &&
               line_mem[5] == nsfc_pkg::CHAR_A)))
            forward_line(fill_count);
         capturing = 1'b0;
         fill_count = 0;
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("MISMATCH word %0d, %s: got %h, expected %h", words_checked, what, got, want);
   endtask

   // Input driver. A beat is taken when valid and ready meet at an edge; the byte goes to
   // the predictor right there. A new byte is offered only once the slot is free, and the
   // sender idles at random according to the current traffic mode.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            frame_byte(req_tdata);
            bytes_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= byte_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Every word taken is checked field by field against the oldest
   // expectation. Ready is withdrawn at random, and for one long stretch on request so
   // that the block backs up into its input.
   always @(posedge clock) begin : result_monitor
      chunk_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_checked++;
            if (pending_words.size() == 0) begin
               report_mismatch("word with nothing pending", rsp_tdata[63:0], 64'd0);
            end else begin
               want = pending_words.pop_front();
               if (rsp_tdata[63:0] !== want.data)
                  report_mismatch("chunk_data", rsp_tdata[63:0], want.data);
               if (rsp_tdata[67:64] !== want.count)
                  report_mismatch("byte_count", 64'(rsp_tdata[67:64]), 64'(want.count));
               if (rsp_tdata[71:68] !== 4'd0)
                  report_mismatch("pad bits", 64'(rsp_tdata[71:68]), 64'd0);
               if (rsp_tuser[0] !== want.chunk_end)
                  report_mismatch("chunk_end", 64'(rsp_tuser[0]), 64'(want.chunk_end));
               if (rsp_tlast !== want.sentence_end)
                  report_mismatch("sentence_end", 64'(rsp_tlast), 64'(want.sentence_end));
               if (rsp_tuser[1] !== want.to_first)
                  report_mismatch("to_first_service", 64'(rsp_tuser[1]), 64'(want.to_first));
               if (rsp_tuser[2] !== want.to_second)
                  report_mismatch("to_second_service", 64'(rsp_tuser[2]), 64'(want.to_second));
            end
         end
         if (hold_left == 0 && holds_started != hold_requests) begin
            holds_started++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Watchdog: any beat on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("Timeout: no beat for %0d cycles, %0d words still pending",
               STALL_LIMIT, pending_words.size());
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(255));
      while (b == nsfc_pkg::CHAR_DOLLAR || b == nsfc_pkg::CHAR_NEWLINE);
      return b;
   endfunction

   // A one-bit register value, sometimes with junk above bit 0 that the block must ignore.
   function automatic logic [9:0] flag_value(logic b);
      logic [8:0] junk;
      junk = $urandom_range(1) ? 9'($urandom_range(511)) : 9'd0;
      return {junk, b};
   endfunction

   task automatic queue_byte(logic [7:0] b);
      byte_queue.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_text(string s);
      for (int i = 0; i < s.len(); i++)
         queue_byte(s[i]);
   endtask

   // Queue a sentence of len bytes in total. A closed one ends in a newline; an open one
   // simply stops, so the next dollar sign restarts the line.
   task automatic queue_sentence(line_kind_type kind, int len, bit closed);
      logic [7:0] text [$];
      int         spot;
      text.push_back(nsfc_pkg::CHAR_DOLLAR);
      text.push_back(nsfc_pkg::CHAR_G);
      text.push_back(body_byte());
      if (kind == LINE_GGA) begin
         text.push_back(nsfc_pkg::CHAR_G);
         text.push_back(nsfc_pkg::CHAR_G);
         text.push_back(nsfc_pkg::CHAR_A);
      end else begin
         text.push_back(nsfc_pkg::CHAR_R);
         text.push_back(nsfc_pkg::CHAR_M);
         text.push_back(nsfc_pkg::CHAR_C);
      end
      if (kind == LINE_OFF_HEADER) begin
         spot = ($urandom_range(3) == 0) ? 1 : int'($urandom_range(3, 5));
         text[spot] = 8'($urandom_range(8'h41, 8'h5A));
      end
      while (text.size() < len - int'(closed))
         text.push_back(body_byte());
      while (text.size() > len - int'(closed))
         void'(text.pop_back());
      if (closed)
         text.push_back(nsfc_pkg::CHAR_NEWLINE);
      foreach (text[i])
         queue_byte(text[i]);
   endtask

   // Mostly well-formed sentences with random content and length; the rest are off headers,
   // short lines, lines cut off by the next dollar sign, and stray bytes between lines.
   task automatic queue_traffic(int amount);
      int stop;
      int pick;
      int len;
      stop = bytes_queued + amount;
      while (bytes_queued < stop) begin
         pick = int'($urandom_range(99));
         len = ($urandom_range(7) == 0) ? int'($urandom_range(25, 70)) :
                                          int'($urandom_range(7, 22));
         if (pick < 40)
            queue_sentence(LINE_RMC, len, 1'b1);
         else if (pick < 70)
            queue_sentence(LINE_GGA, len, 1'b1);
         else if (pick < 80)
            queue_sentence(LINE_OFF_HEADER, len, 1'b1);
         else if (pick < 87)
            queue_sentence(pick[0] ? LINE_RMC : LINE_GGA, int'($urandom_range(2, 6)), 1'b1);
         else if (pick < 94)
            queue_sentence(LINE_GGA, int'($urandom_range(2, 20)), 1'b0);
         else
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(255)));
      end
   endtask

   // One register write; the predictor takes the new value once the beat has gone through.
   task automatic write_csr(nsfc_pkg::csr_index_type idx, logic [9:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         nsfc_pkg::CSR_LINK_CONNECTED: cfg_connected = value[0];
         nsfc_pkg::CSR_FIRST_ON:       cfg_first = value[0];
         nsfc_pkg::CSR_SECOND_ON:      cfg_second = value[0];
         nsfc_pkg::CSR_LINK_MTU:       cfg_mtu = value;
         default:                      ;
      endcase
   endtask

   task automatic set_config(logic connected, logic first, logic second, logic [9:0] mtu);
      write_csr(nsfc_pkg::CSR_LINK_CONNECTED, flag_value(connected));
      write_csr(nsfc_pkg::CSR_FIRST_ON, flag_value(first));
      write_csr(nsfc_pkg::CSR_SECOND_ON, flag_value(second));
      write_csr(nsfc_pkg::CSR_LINK_MTU, mtu);
      settings_applied++;
   endtask

   // Traffic modes: steady, sender gaps, receiver stalls, and both at once.
   task automatic set_mode(int mode);
      case (mode)
         1:       begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
         2:       begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
         3:       begin sender_idle_pct = 19; receiver_stall_pct = 19; end
         default: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      endcase
   endtask

   // Wait until every byte is taken and every expected word has arrived, then let the
   // block finish whatever a rejected line may still occupy it with.
   task automatic drain(int settle);
      while (byte_queue.size() != 0 || req_tvalid || pending_words.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: stray bytes while idle are ignored, the shortest RMC line is sent,
      // a dollar sign in mid-line restarts it into a GGA line, and a six-byte line is dropped.
      set_mode(0);
      set_config(1'b1, 1'b1, 1'b0, nsfc_pkg::MIN_MTU);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_text("$GPRMC\n");
      queue_text("$GP$GLGGA\n");
      queue_text("$GPRM\n");
      drain(PHASE_SETTLE);

      // Random part over a spread of settings, each with its own traffic mode. The transfer
      // unit runs through zero, just below and just above the floor, the top of the normal
      // range and the largest value the register holds.
      for (int p = 0; p < 8; p++) begin
         set_mode(p % 4);
         case (p)
            0: set_config(1'b1, 1'b1, 1'b1, 10'd0);
            1: set_config(1'b1, 1'b0, 1'b1, 10'd24);
            2: set_config(1'b1, 1'b1, 1'b0, 10'd1023);
            3: set_config(1'b0, 1'b1, 1'b1, 10'd100);
            4: set_config(1'b1, 1'b0, 1'b0, 10'd517);
            5: set_config(1'b1, 1'b1, 1'b1, 10'd22);
            6: set_config(1'b1, 1'b1, 1'b1, 10'd517);
            default: set_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                                1'($urandom_range(1)), 10'($urandom_range(1023)));
         endcase
         // The longest line that fits, cut into the most words at the smallest chunk size.
         if (p == 0)
            queue_sentence(LINE_RMC, LINE_BYTES - 1, 1'b1);
         // Overflow: the newline is the byte that no longer fits, so nothing is sent.
         if (p == 2)
            queue_sentence(LINE_GGA, LINE_BYTES, 1'b1);
         // The receiver holds off for a long stretch while the sender keeps offering bytes.
         if (p == 5)
            hold_requests++;
         queue_traffic(PHASE_BYTES);
         drain(PHASE_SETTLE);
      end

      drain(FINAL_SETTLE);
      $display("Covered %0d receiver bytes under %0d register settings, %0d lines forwarded.",
               bytes_accepted, settings_applied, lines_forwarded);
      $display("Checked %0d result words; the longest line left as %0d words.",
               words_checked, most_words);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
rtl/nsfc_pkg.sv
rtl/nsfc_line_capture.sv
rtl/nmea_sentence_filter_chunker_top.sv
sim/tb_nmea_sentence_filter_chunker_top.sv
